[rtl/srss_pkg.sv]
// Shared types, codes and constants for the sorted record store.
package srss_pkg;

	localparam int DEFAULT_CAPACITY = 64;

	localparam int KEY_W    = 16;
	localparam int COPIES_W = 16;
	localparam int POS_W    = 7;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_QUERY = 2'd1;

	localparam logic [POS_W-1:0] NO_POSITION = 7'h7F;

	typedef enum logic [2:0] {
		ST_LOADED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_FOUND   = 3'd2,
		ST_MISSING = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		RIDX_HOLD = 2'd0,
		RIDX_LAST = 2'd1,
		RIDX_DEC  = 2'd2,
		RIDX_INC  = 2'd3
	} ridx_op_t;

	typedef enum logic [1:0] {
		WR_SHIFT     = 2'd0,
		WR_NEW_ABOVE = 2'd1,
		WR_NEW_ZERO  = 2'd2
	} wr_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [COPIES_W-1:0] copies;
	} entry_t;

	typedef struct packed {
		logic     capture;
		logic     rd_en;
		ridx_op_t ridx_op;
		logic     ridx_zero;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     cnt_clear;
		logic     cnt_inc;
		logic     res_set;
		status_t  res_code;
		logic     res_found;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic is_load;
		logic full;
		logic empty;
		logic key_le;
		logic key_eq;
		logic ridx_last;
		logic ridx_zero;
	} dp_stat_t;

endpackage

[rtl/srss_dpath.sv]
// Datapath of the sorted record store: record memory, counters and result registers.
module srss_dpath
	import srss_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ctrl_cmd_t                  cmd,
	output dp_stat_t                   stat,
	input  logic [1:0]                 action,
	input  logic [KEY_W-1:0]           key,
	input  logic [COPIES_W-1:0]        copy_count,
	output logic [2:0]                 status,
	output logic signed [POS_W-1:0]    position,
	output logic [COPIES_W-1:0]        found_copies
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	entry_t mem [CAPACITY];

	logic [1:0]          act_q;
	logic [KEY_W-1:0]    key_q;
	logic [COPIES_W-1:0] copies_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       ridx_q;
	logic [AW-1:0]       ridx_d;
	entry_t              rd_q;

	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;
	logic [AW+POS_W-1:0] pos_ext;

	status_t             res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	logic [COPIES_W-1:0] res_copies_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_clear) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= action;
			key_q    <= key;
			copies_q <= copy_count;
		end
	end

	always_comb begin
		case (cmd.ridx_op)
			RIDX_HOLD: ridx_d = ridx_q;
			RIDX_LAST: ridx_d = count_q[AW-1:0] - 1'b1;
			RIDX_DEC:  ridx_d = ridx_q - 1'b1;
			RIDX_INC:  ridx_d = ridx_q + 1'b1;
			default:   ridx_d = ridx_q;
		endcase
		if (cmd.ridx_zero) begin
			ridx_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= ridx_d;
		if (cmd.rd_en) begin
			rd_q <= mem[ridx_d];
		end
	end

	always_comb begin
		case (cmd.wr_sel)
			WR_SHIFT: begin
				wr_addr = ridx_q + 1'b1;
				wr_data = rd_q;
			end
			WR_NEW_ABOVE: begin
				wr_addr = ridx_q + 1'b1;
				wr_data = '{key: key_q, copies: copies_q};
			end
			WR_NEW_ZERO: begin
				wr_addr = '0;
				wr_data = '{key: key_q, copies: copies_q};
			end
			default: begin
				wr_addr = '0;
				wr_data = '{key: key_q, copies: copies_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign stat.is_clear  = act_q[1];
	assign stat.is_load   = (act_q == ACT_LOAD);
	assign stat.full      = (count_q >= CW'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.key_le    = (key_q <= rd_q.key);
	assign stat.key_eq    = (key_q == rd_q.key);
	assign stat.ridx_last = ((CW'(ridx_q) + 1'b1) == count_q);
	assign stat.ridx_zero = (ridx_q == '0);

	assign pos_ext = {{POS_W{1'b0}}, ridx_q};

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_status_q <= cmd.res_code;
			res_pos_q    <= cmd.res_found ? pos_ext[POS_W-1:0] : NO_POSITION;
			res_copies_q <= cmd.res_found ? rd_q.copies : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status       <= res_status_q;
			position     <= res_pos_q;
			found_copies <= res_copies_q;
		end
	end

endmodule

[rtl/srss_ctrl.sv]
// Controller state machine of the sorted record store.
module srss_ctrl
	import srss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_CMP    = 5'b00100,
		S_PLACE  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.is_clear) begin
					cmd.cnt_clear = 1'b1;
					cmd.res_set   = 1'b1;
					cmd.res_code  = ST_CLEARED;
					state_d       = S_DONE;
				end else if (stat.is_load) begin
					if (stat.full) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_FULL;
						state_d      = S_DONE;
					end else if (stat.empty) begin
						cmd.wr_en    = 1'b1;
						cmd.wr_sel   = WR_NEW_ZERO;
						cmd.cnt_inc  = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_LOADED;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.ridx_op = RIDX_LAST;
						state_d     = S_CMP;
					end
				end else begin
					if (stat.empty) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_MISSING;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en     = 1'b1;
						cmd.ridx_zero = 1'b1;
						state_d       = S_CMP;
					end
				end
			end
			S_CMP: begin
				if (stat.is_load) begin
					if (stat.key_le) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_SHIFT;
						if (stat.ridx_zero) begin
							state_d = S_PLACE;
						end else begin
							cmd.rd_en   = 1'b1;
							cmd.ridx_op = RIDX_DEC;
						end
					end else begin
						cmd.wr_en    = 1'b1;
						cmd.wr_sel   = WR_NEW_ABOVE;
						cmd.cnt_inc  = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_LOADED;
						state_d      = S_DONE;
					end
				end else begin
					if (stat.key_eq) begin
						cmd.res_set   = 1'b1;
						cmd.res_code  = ST_FOUND;
						cmd.res_found = 1'b1;
						state_d       = S_DONE;
					end else if (stat.ridx_last) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_MISSING;
						state_d      = S_DONE;
					end else begin
						cmd.rd_en   = 1'b1;
						cmd.ridx_op = RIDX_INC;
					end
				end
			end
			S_PLACE: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_NEW_ZERO;
				cmd.cnt_inc  = 1'b1;
				cmd.res_set  = 1'b1;
				cmd.res_code = ST_LOADED;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/sorted_record_store_with_search_unit.sv]
// Top level of the sorted record store with linear search.
//
// The block holds up to CAPACITY records, each a 16-bit key and a 16-bit copy
// count, in ascending key order in a memory with one read port, one write port
// and a registered read.
// Every item gives exactly one result item. A load item (action 0) inserts its
// record by insertion sort: starting from the top of the table, each record
// whose key is greater than or equal to the new key is read and moved up by
// one place, so the new record lands before any records with an equal key;
// when the table is full the load is dropped and reported with status 1. A
// query item (action 1) scans upwards from position 0 and reports the first
// record with a matching key (status 2, its position and copy count), or
// status 3 with position -1 and zero copies. A clear item (action 2, and the
// unused action 3) empties the table in one step with status 4. Loads, full
// loads and clears always report position -1 and zero copies. Positions are
// reported masked to seven bits, so those above 63 read as negative. A clear,
// a full load or a load into an empty table is finished in the decode state;
// a load that moves records does one memory read-compare-write per moved
// record and then writes the new record; a query reads and compares one
// record per step from position 0 until a match or the last record. The next
// item is taken only once the result has gone to the output register. A
// finished result waits in the output register while the following item is
// taken and worked on; that item's result is held back until the output
// register has been emptied.
module sorted_record_store_with_search_unit
	import srss_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [KEY_W-1:0]        key,
	input  logic [COPIES_W-1:0]     copy_count,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [2:0]              status,
	output logic signed [POS_W-1:0] position,
	output logic [COPIES_W-1:0]     found_copies
);

	// Commands from the controller to the datapath, and status flags back.
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	srss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the record memory, the record count, the scan index,
	// the pending result and the output register.
	srss_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.key          (key),
		.copy_count   (copy_count),
		.status       (status),
		.position     (position),
		.found_copies (found_copies)
	);

endmodule

[tb/srss_result_checker.sv]
// Checker that mirrors the sorted record table and compares every result item.
`timescale 1ns / 1ps

module srss_result_checker
	import srss_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          action,
	input  logic [KEY_W-1:0]    key,
	input  logic [COPIES_W-1:0] copy_count,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [2:0]          status,
	input  logic [POS_W-1:0]    position,
	input  logic [COPIES_W-1:0] found_copies,
	output int                  mismatches,
	output int                  pending,
	output int                  found_hits,
	output int                  full_hits
);

	typedef struct {
		status_t             status;
		logic [POS_W-1:0]    position;
		logic [COPIES_W-1:0] copies;
	} record_result_t;

	logic [KEY_W-1:0]    shadow_keys   [CAPACITY];
	logic [COPIES_W-1:0] shadow_copies [CAPACITY];
	int                  shadow_count;

	record_result_t awaited_results [$];
	record_result_t want;
	int             error_total;
	int             result_index;
	int             hit_total;
	int             full_total;

	// Updates the mirrored table with one item and returns the result it must give.
	function automatic record_result_t store_and_predict(input logic [1:0] act,
			input logic [KEY_W-1:0] k, input logic [COPIES_W-1:0] c);
		record_result_t r;
		int slot;
		int i;
		r.status   = ST_LOADED;
		r.position = NO_POSITION;
		r.copies   = '0;
		if (act == ACT_LOAD) begin
			if (shadow_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				slot = shadow_count;
				while (slot > 0 && k <= shadow_keys[slot-1]) begin
					shadow_keys[slot]   = shadow_keys[slot-1];
					shadow_copies[slot] = shadow_copies[slot-1];
					slot--;
				end
				shadow_keys[slot]   = k;
				shadow_copies[slot] = c;
				shadow_count++;
			end
		end else if (act == ACT_QUERY) begin
			r.status = ST_MISSING;
			for (i = 0; i < shadow_count; i++) begin
				if (shadow_keys[i] == k) begin
					r.status   = ST_FOUND;
					r.position = POS_W'(i);
					r.copies   = shadow_copies[i];
					break;
				end
			end
		end else begin
			// Both upper action codes empty the table.
			shadow_count = 0;
			r.status     = ST_CLEARED;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaited_results.delete();
			shadow_count = 0;
			error_total  = 0;
			result_index = 0;
			hit_total    = 0;
			full_total   = 0;
			mismatches   <= 0;
			pending      <= 0;
			found_hits   <= 0;
			full_hits    <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_results.insert(awaited_results.size(),
					store_and_predict(action, key, copy_count));
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					error_total++;
					if (error_total <= 10) begin
						$display("ERROR: result %0d arrived with nothing awaited: status %0d",
							result_index, status);
					end
				end else begin
					want = awaited_results.pop_front();
					if (want.status == ST_FOUND) hit_total++;
					if (want.status == ST_FULL) full_total++;
					if (status !== want.status || position !== want.position ||
							found_copies !== want.copies) begin
						error_total++;
						if (error_total <= 10) begin
							$display("ERROR: result %0d: got status %0d position 0x%02h copies 0x%04h",
								result_index, status, position, found_copies);
							$display("       expected status %0d position 0x%02h copies 0x%04h",
								want.status, want.position, want.copies);
						end
					end
				end
				result_index++;
			end
			mismatches <= error_total;
			pending    <= awaited_results.size();
			found_hits <= hit_total;
			full_hits  <= full_total;
		end
	end

endmodule

[tb/sorted_record_store_with_search_unit_tb.sv]
// Stimulus, clock, reset and verdict for the sorted record store testbench.
`timescale 1ns / 1ps

module sorted_record_store_with_search_unit_tb;
	import srss_pkg::*;

	// The package only names the load and query codes; the two clearing codes
	// are only produced here.
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Length of the deliberate receiver hold-off, long enough for the block to
	// fill its output register and push back on the sender many times over.
	localparam int HOLD_CYCLES = 400;
	// Cycles allowed after the last result for any stray item to show up.
	localparam int SETTLE_CYCLES = 150;
	localparam int PHASE_ITEMS = 380;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic [1:0]              action     = ACT_LOAD;
	logic [KEY_W-1:0]        key        = '0;
	logic [COPIES_W-1:0]     copy_count = '0;
	logic                    out_stall  = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic [2:0]              status;
	logic signed [POS_W-1:0] position;
	logic [COPIES_W-1:0]     found_copies;

	int mismatches;
	int pending;
	int found_hits;
	int full_hits;

	// Idle percentages of the two sides, changed by the stimulus between phases.
	int   tx_idle_pct    = 0;
	int   rx_idle_pct    = 0;
	logic receiver_hold  = 1'b0;

	int items_sent   = 0;
	int loads_sent   = 0;
	int queries_sent = 0;
	int clears_sent  = 0;

	// A short ring of recently loaded keys, so that many queries hit.
	logic [KEY_W-1:0] recent_keys [16];
	logic [3:0]       recent_wr = '0;

	always #10 clk = ~clk;

	sorted_record_store_with_search_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key          (key),
		.copy_count   (copy_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.position     (position),
		.found_copies (found_copies)
	);

	srss_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.key          (key),
		.copy_count   (copy_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.position     (position),
		.found_copies (found_copies),
		.mismatches   (mismatches),
		.pending      (pending),
		.found_hits   (found_hits),
		.full_hits    (full_hits)
	);

	// The receiver stalls at random at the current idle rate, and holds off
	// completely while a long hold is in force.
	always @(posedge clk) begin
		if (receiver_hold) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// Offers one item, after a random number of idle cycles, and returns once the
	// block has taken it. The valid is only lowered in a cycle of its own, so it
	// never falls and rises within the same time step.
	task automatic offer_item(input logic [1:0] act, input logic [KEY_W-1:0] k,
			input logic [COPIES_W-1:0] c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		key        <= k;
		copy_count <= c;
		do @(posedge clk); while (in_stall);
		items_sent++;
		case (act)
			ACT_LOAD: begin
				loads_sent++;
				recent_keys[recent_wr] = k;
				recent_wr++;
			end
			ACT_QUERY: queries_sent++;
			default:   clears_sent++;
		endcase
	endtask

	// Pauses the sender until every awaited result has come back. The first
	// edge lets the checker register the last accepted item before it is read.
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Keys of a session: tightly packed at one end of the range, clustered round
	// a random base, or spread over the whole sixteen bits.
	function automatic logic [KEY_W-1:0] session_key(input int mode,
			input logic [KEY_W-1:0] base);
		case (mode)
			0:       return base + KEY_W'($urandom_range(0, 15));
			1:       return base + KEY_W'($urandom_range(0, 255));
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// One session starts from an empty table and mixes loads and queries. Its
	// load share decides how deep the table grows; the heaviest setting fills it
	// and runs into dropped loads.
	task automatic random_session(input int len);
		int               load_pct;
		int               mode;
		int               i;
		int               r;
		logic [KEY_W-1:0] base;
		logic [KEY_W-1:0] k;
		logic [COPIES_W-1:0] c;
		case ($urandom_range(0, 2))
			0:       load_pct = 35;
			1:       load_pct = 65;
			default: load_pct = 92;
		endcase
		mode = $urandom_range(0, 2);
		if (mode == 0) begin
			base = $urandom_range(0, 1) ? 16'h0000 : 16'hFFF0;
		end else begin
			base = KEY_W'($urandom);
		end
		offer_item(($urandom_range(0, 3) == 0) ? ACT_SPARE : ACT_CLEAR,
			KEY_W'($urandom), COPIES_W'($urandom));
		for (i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < load_pct) begin
				k = session_key(mode, base);
				case ($urandom_range(0, 9))
					0:       c = '0;
					1:       c = '1;
					default: c = COPIES_W'($urandom);
				endcase
				offer_item(ACT_LOAD, k, c);
			end else if (r < 98) begin
				if ($urandom_range(0, 99) < 55) begin
					k = recent_keys[$urandom_range(0, 15)];
				end else begin
					k = session_key(mode, base);
				end
				offer_item(ACT_QUERY, k, COPIES_W'($urandom));
			end else begin
				// An occasional clear in the middle of a session.
				offer_item(($urandom_range(0, 1) == 0) ? ACT_SPARE : ACT_CLEAR,
					KEY_W'($urandom), COPIES_W'($urandom));
			end
		end
	endtask

	// Runs sessions of random length until the phase has sent its share of items.
	task automatic random_phase(input int tx_pct, input int rx_pct, input int quota);
		int start;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start       = items_sent;
		while (items_sent - start < quota) begin
			random_session($urandom_range(5, 90));
		end
	endtask

	initial begin
		int i;
		for (i = 0; i < 16; i++) recent_keys[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 24;
		rx_idle_pct = 72;

		// Directed part. A query on the empty table misses; then records at the
		// key extremes go in, with a repeated key whose second copy must land in
		// front of the first.
		offer_item(ACT_QUERY, 16'h0000, 16'h0000);
		offer_item(ACT_LOAD,  16'h8000, 16'hFFFF);
		offer_item(ACT_LOAD,  16'h0000, 16'h0000);
		offer_item(ACT_LOAD,  16'hFFFF, 16'h5A5A);
		offer_item(ACT_LOAD,  16'h8000, 16'h0001);
		offer_item(ACT_LOAD,  16'h7FFF, 16'hA5A5);
		// A hit at position zero, the first of two equal keys, the top entry, the
		// record just below the equal pair, and two misses.
		offer_item(ACT_QUERY, 16'h0000, 16'hFFFF);
		offer_item(ACT_QUERY, 16'h8000, 16'h0000);
		offer_item(ACT_QUERY, 16'hFFFF, 16'h0000);
		offer_item(ACT_QUERY, 16'h7FFF, 16'h0000);
		offer_item(ACT_QUERY, 16'h1234, 16'h0000);
		offer_item(ACT_QUERY, 16'hFFFE, 16'h0000);
		// The unused action code behaves as a clear.
		offer_item(ACT_SPARE, 16'hFFFF, 16'hFFFF);
		offer_item(ACT_QUERY, 16'h8000, 16'h0000);
		offer_item(ACT_LOAD,  16'h0001, 16'hFFFF);
		offer_item(ACT_LOAD,  16'h0001, 16'h0000);
		offer_item(ACT_QUERY, 16'h0001, 16'h0000);
		offer_item(ACT_CLEAR, 16'h0000, 16'h0000);
		offer_item(ACT_QUERY, 16'hFFFF, 16'h0000);

		// Pressure: the receiver holds off for a long stretch while the sender
		// fills the table with falling keys, so that each load shifts every
		// record; the last few loads find the table full. Then the sender pauses
		// until everything has drained.
		offer_item(ACT_CLEAR, 16'h0000, 16'h0000);
		fork
			begin
				receiver_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				receiver_hold <= 1'b0;
			end
		join_none
		for (i = 0; i < DEFAULT_CAPACITY + 6; i++) begin
			offer_item(ACT_LOAD, 16'hFFFF - KEY_W'(i * 3), COPIES_W'(i));
		end
		offer_item(ACT_QUERY, 16'hFFFF - KEY_W'((DEFAULT_CAPACITY - 1) * 3), 16'h0000);
		offer_item(ACT_QUERY, 16'hFFFF, 16'h0000);
		offer_item(ACT_QUERY, 16'hFFFE, 16'h0000);
		wait_all_results();

		// Random part in three phases of idling.
		random_phase(24, 72, PHASE_ITEMS);
		random_phase(72, 24, PHASE_ITEMS);
		random_phase(0, 0, PHASE_ITEMS);

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items: %0d loads, %0d queries, %0d clears.",
			items_sent, loads_sent, queries_sent, clears_sent);
		$display("Queries that hit a record: %0d; loads dropped on a full table: %0d.",
			found_hits, full_hits);
		if (mismatches == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: a correct run needs a small fraction of this.
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
